// ----- rtl/hwpc_pkg.sv -----
`timescale 1ns / 1ps

package hwpc_pkg;

  // Field and datapath widths.
  localparam int IDX_W  = 12;  // domain_index
  localparam int CNT_W  = 13;  // color_count register
  localparam int SLOT_W = 13;  // scrambled slot j, always below the count
  localparam int NUM_W  = 22;  // 360 * j
  localparam int HUE_W  = 9;   // whole-degree hue, below 360
  localparam int OFS_W  = 6;   // offset inside a sector, below 60
  localparam int CH_W   = 8;   // one color channel

  // Configuration port layout.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic [0:0] REG_COLOR_COUNT = 1'b0;  // register index, taken from paddr[2]

  localparam logic [CNT_W-1:0] COLOR_COUNT_RST = 13'd8;
  localparam int MAX_COLORS_DEF = 4096;

  // Hue wheel constants.
  localparam int HUE_FULL   = 360;
  localparam int SECTOR_DEG = 60;
  localparam logic [CH_W-1:0] CH_FULL = 8'd255;

  // Queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic              known;
    logic [SLOT_W-1:0] slot;
  } hwpc_item_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } hwpc_qstat_t;

endpackage

// ----- rtl/hwpc_front.sv -----
`timescale 1ns / 1ps

module hwpc_front (
  input  logic [hwpc_pkg::IDX_W-1:0] domain_index,
  input  logic                       accept,
  input  logic [hwpc_pkg::CNT_W-1:0] eff_count,
  output logic                       push,
  output hwpc_pkg::hwpc_item_t       item
);

  logic [hwpc_pkg::CNT_W-1:0]  idx_ext;
  logic [hwpc_pkg::CNT_W-1:0]  half;
  logic [hwpc_pkg::CNT_W:0]    even_sum;
  logic [hwpc_pkg::CNT_W:0]    even_red;
  logic [hwpc_pkg::CNT_W:0]    odd_sum;
  logic [hwpc_pkg::SLOT_W-1:0] slot_even;
  logic [hwpc_pkg::SLOT_W-1:0] slot_odd;

  assign idx_ext = hwpc_pkg::CNT_W'(domain_index);
  assign half    = eff_count >> 1;

  // Even count n = 2h: idx*(h+1) mod n is idx, plus h for an odd idx, reduced once.
  assign even_sum  = (hwpc_pkg::CNT_W+1)'(idx_ext) +
                     (domain_index[0] ? (hwpc_pkg::CNT_W+1)'(half) : '0);
  assign even_red  = (even_sum >= (hwpc_pkg::CNT_W+1)'(eff_count)) ?
                     even_sum - (hwpc_pkg::CNT_W+1)'(eff_count) : even_sum;
  assign slot_even = even_red[hwpc_pkg::SLOT_W-1:0];

  // Odd count: h+1 is the inverse of two, so the slot is idx/2 or (idx+n)/2.
  assign odd_sum  = (hwpc_pkg::CNT_W+1)'(idx_ext) +
                    (domain_index[0] ? (hwpc_pkg::CNT_W+1)'(eff_count) : '0);
  assign slot_odd = odd_sum[hwpc_pkg::SLOT_W:1];

  // Classify and hand the transaction to the queue.
  assign push       = accept;
  assign item.known = (eff_count != '0) && (idx_ext < eff_count);
  assign item.slot  = eff_count[0] ? slot_odd : slot_even;

endmodule

// ----- rtl/hwpc_queue.sv -----
`timescale 1ns / 1ps

module hwpc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hwpc_pkg::hwpc_item_t push_item,
  input  logic                 pop,
  output hwpc_pkg::hwpc_item_t pop_item,
  output hwpc_pkg::hwpc_qstat_t stat
);

  hwpc_pkg::hwpc_item_t             entry_r [hwpc_pkg::QUEUE_DEPTH];
  logic [hwpc_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [hwpc_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [hwpc_pkg::QPTR_W:0]        count_r, count_nxt;

  assign stat.full  = (count_r == (hwpc_pkg::QPTR_W+1)'(hwpc_pkg::QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_item   = entry_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ----- rtl/hwpc_back.sv -----
`timescale 1ns / 1ps

module hwpc_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [hwpc_pkg::CNT_W-1:0] eff_count,
  input  hwpc_pkg::hwpc_qstat_t      qstat,
  input  hwpc_pkg::hwpc_item_t       q_item,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [31:0]                out_tdata,
  output logic [0:0]                 out_tuser
);

  localparam int STAGES = hwpc_pkg::HUE_W + 1;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  logic                         adv;

  // Divider pipeline: index 0 holds 360*j, each later index resolves one quotient bit.
  logic                         vld_r   [STAGES];
  logic                         known_r [STAGES];
  logic [hwpc_pkg::NUM_W-1:0]   rem_r   [STAGES];
  logic [hwpc_pkg::HUE_W-1:0]   quo_r   [STAGES];
  logic [hwpc_pkg::NUM_W-1:0]   rem_nxt [STAGES];
  logic [hwpc_pkg::HUE_W-1:0]   quo_nxt [STAGES];

  // Sector stage.
  logic                         s_vld_r, s_known_r;
  sector_t                      s_sec_r, s_sec_nxt;
  logic [hwpc_pkg::OFS_W-1:0]   s_ofs_r, s_ofs_nxt;
  logic [hwpc_pkg::HUE_W-1:0]   hue;
  logic [hwpc_pkg::HUE_W-1:0]   sec_base;

  // Output register.
  logic                         o_vld_r;
  logic [31:0]                  o_data_r, o_data_nxt;
  logic [0:0]                   o_user_r, o_user_nxt;
  logic [9:0]                   rise_prod, fall_prod;
  logic [hwpc_pkg::OFS_W:0]     fall_ofs;
  logic [hwpc_pkg::CH_W-1:0]    rise, fall, red, green, blue;

  // The whole back moves as one when the output slot is free or being taken.
  assign adv   = !o_vld_r || out_tready;
  assign q_pop = adv && !qstat.empty;

  // Restoring division steps against the count shifted into place.
  always_comb begin
    for (int k = 0; k < STAGES - 1; k++) begin
      logic [hwpc_pkg::NUM_W-1:0] dv;
      dv = hwpc_pkg::NUM_W'(eff_count) << (hwpc_pkg::HUE_W - 1 - k);
      if (rem_r[k] >= dv) begin
        rem_nxt[k+1] = rem_r[k] - dv;
        quo_nxt[k+1] = quo_r[k] | (hwpc_pkg::HUE_W'(1) << (hwpc_pkg::HUE_W - 1 - k));
      end else begin
        rem_nxt[k+1] = rem_r[k];
        quo_nxt[k+1] = quo_r[k];
      end
    end
    rem_nxt[0] = hwpc_pkg::NUM_W'(q_item.slot) * hwpc_pkg::NUM_W'(hwpc_pkg::HUE_FULL);
    quo_nxt[0] = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < STAGES; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= !qstat.empty;
      for (int k = 1; k < STAGES; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      known_r[0] <= q_item.known;
      rem_r[0]   <= rem_nxt[0];
      quo_r[0]   <= quo_nxt[0];
      for (int k = 1; k < STAGES; k++) begin
        known_r[k] <= known_r[k-1];
        rem_r[k]   <= rem_nxt[k];
        quo_r[k]   <= quo_nxt[k];
      end
    end
  end

  // Split the hue into its sector and the offset inside it.
  assign hue = quo_r[STAGES-1];

  always_comb begin
    if (hue >= hwpc_pkg::HUE_W'(5 * hwpc_pkg::SECTOR_DEG)) begin
      s_sec_nxt = SEC_MAG_RED;
    end else if (hue >= hwpc_pkg::HUE_W'(4 * hwpc_pkg::SECTOR_DEG)) begin
      s_sec_nxt = SEC_BLU_MAG;
    end else if (hue >= hwpc_pkg::HUE_W'(3 * hwpc_pkg::SECTOR_DEG)) begin
      s_sec_nxt = SEC_CYN_BLU;
    end else if (hue >= hwpc_pkg::HUE_W'(2 * hwpc_pkg::SECTOR_DEG)) begin
      s_sec_nxt = SEC_GRN_CYN;
    end else if (hue >= hwpc_pkg::HUE_W'(hwpc_pkg::SECTOR_DEG)) begin
      s_sec_nxt = SEC_YEL_GRN;
    end else begin
      s_sec_nxt = SEC_RED_YEL;
    end
    sec_base  = hwpc_pkg::HUE_W'(s_sec_nxt) * hwpc_pkg::HUE_W'(hwpc_pkg::SECTOR_DEG);
    s_ofs_nxt = hwpc_pkg::OFS_W'(hue - sec_base);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (adv) begin
      s_vld_r <= vld_r[STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_known_r <= known_r[STAGES-1];
      s_sec_r   <= s_sec_nxt;
      s_ofs_r   <= s_ofs_nxt;
    end
  end

  // Rising and falling ramps, 17/4 per degree, then the sector table.
  always_comb begin
    fall_ofs  = (hwpc_pkg::OFS_W+1)'(hwpc_pkg::SECTOR_DEG) - (hwpc_pkg::OFS_W+1)'(s_ofs_r);
    rise_prod = (10'(s_ofs_r) << 4) + 10'(s_ofs_r);
    fall_prod = (10'(fall_ofs) << 4) + 10'(fall_ofs);
    rise      = rise_prod[9:2];
    fall      = fall_prod[9:2];
    case (s_sec_r)
      SEC_RED_YEL: begin red = hwpc_pkg::CH_FULL; green = rise;             blue = '0; end
      SEC_YEL_GRN: begin red = fall;              green = hwpc_pkg::CH_FULL; blue = '0; end
      SEC_GRN_CYN: begin red = '0; green = hwpc_pkg::CH_FULL; blue = rise;              end
      SEC_CYN_BLU: begin red = '0; green = fall;              blue = hwpc_pkg::CH_FULL; end
      SEC_BLU_MAG: begin red = rise;              green = '0; blue = hwpc_pkg::CH_FULL; end
      default:     begin red = hwpc_pkg::CH_FULL; green = '0; blue = fall;              end
    endcase
    if (s_known_r) begin
      o_data_nxt = {hwpc_pkg::CH_FULL, blue, green, red};
      o_user_nxt = 1'b1;
    end else begin
      o_data_nxt = '0;
      o_user_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_data_r <= o_data_nxt;
      o_user_r <= o_user_nxt;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_user_r;

endmodule

// ----- rtl/hue_wheel_palette_color.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Handshake              | Payload
// in_     | in        | in_tvalid / in_tready  | in_tdata[11:0] domain_index
// out_    | out       | out_tvalid / out_tready| out_tdata red, green, blue, alpha;
//         |           |                        | out_tuser valid_res
// cfg_    | in        | APB, pready tied high  | 0x0 color_count (13 bits)
//
// One color per clock is sustained while out_tready is high; from acceptance to out_tvalid
// an item passes, when the queue is empty, the queue write at the accepting edge, then the
// 360*j stage, nine divider stages, sector and output registers.
// The nine-stage restoring divider for floor(360*j/n) sets the latency.
// Synchronous active-low reset empties the queue and the pipeline and sets color_count to 8.
// A stalled output freezes the back; the front keeps taking items until its four-entry
// queue is full.
module hue_wheel_palette_color #(
  parameter int MAX_COLORS = hwpc_pkg::MAX_COLORS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [15:0]                     in_tdata,    // [11:0] domain_index
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata,   // [7:0] red, [15:8] green,
                                                       // [23:16] blue, [31:24] alpha
  output logic [0:0]                      out_tuser,   // [0] valid_res
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hwpc_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [hwpc_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [hwpc_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  localparam int CNT_MAX = (1 << hwpc_pkg::CNT_W) - 1;
  localparam int CLAMP   = (MAX_COLORS < CNT_MAX) ? MAX_COLORS : CNT_MAX;

  logic [hwpc_pkg::CNT_W-1:0] color_count_r, color_count_nxt;
  logic [hwpc_pkg::CNT_W-1:0] eff_count;
  logic                       cfg_wr;
  logic                       in_accept;
  logic                       push, pop;
  hwpc_pkg::hwpc_item_t       push_item, pop_item;
  hwpc_pkg::hwpc_qstat_t      qstat;

  // Register port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == hwpc_pkg::REG_COLOR_COUNT);
  assign color_count_nxt = cfg_wr ? cfg_pwdata[hwpc_pkg::CNT_W-1:0] : color_count_r;
  assign cfg_prdata = (cfg_paddr[2] == hwpc_pkg::REG_COLOR_COUNT) ?
                      hwpc_pkg::CFG_DATA_W'(color_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_count_r <= hwpc_pkg::COLOR_COUNT_RST;
    end else begin
      color_count_r <= color_count_nxt;
    end
  end

  // Count as used, saturated at the palette limit.
  assign eff_count = (color_count_r > hwpc_pkg::CNT_W'(CLAMP)) ?
                     hwpc_pkg::CNT_W'(CLAMP) : color_count_r;

  // Input transaction handshake.
  assign in_tready = !qstat.full;
  assign in_accept = in_tvalid && in_tready;

  hwpc_front u_front (
    .domain_index (in_tdata[hwpc_pkg::IDX_W-1:0]),
    .accept       (in_accept),
    .eff_count    (eff_count),
    .push         (push),
    .item         (push_item)
  );

  hwpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (qstat)
  );

  hwpc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .eff_count  (eff_count),
    .qstat      (qstat),
    .q_item     (pop_item),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import hwpc_pkg::*;

  // One color as it leaves the block.
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            valid_res;
  } color_t;

  // Hue sectors, named after the channel that moves in each.
  typedef enum int unsigned {
    SEC_GREEN_RISE, SEC_RED_FALL, SEC_BLUE_RISE,
    SEC_GREEN_FALL, SEC_RED_RISE, SEC_BLUE_FALL
  } sector_t;

  // One row of the directed stimulus; known colors are typed in where obvious.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] idx;
    logic             typed;
    color_t           want;
  } dir_row_t;

  localparam color_t PURE_RED = '{CH_FULL, 8'd0, 8'd0, CH_FULL, 1'b1};
  localparam color_t NO_COLOR = '0;
  localparam logic [CFG_ADDR_W-1:0] COUNT_ADDR = {REG_COLOR_COUNT, 2'b00};
  localparam int DIR_N       = 25;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 60;
  localparam int SETTLE      = 20;
  localparam int IDLE_LIMIT  = 5000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata = '0;     // [11:0] domain_index
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [31:0]           out_tdata;         // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  logic [0:0]            out_tuser;         // [0] valid_res
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  color_t           pending_colors[$];
  logic [CNT_W-1:0] cur_count = COLOR_COUNT_RST;
  bit               steady = 1'b0;
  int               mismatches = 0;
  int               idle_cycles = 0;

  hue_wheel_palette_color dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // Expected color of a domain under a given count, in exact integer arithmetic.
  function automatic color_t wheel_color(input logic [CNT_W-1:0] count,
                                         input logic [IDX_W-1:0] idx);
    int unsigned n, j, hue, ofs, rise, fall;
    color_t c;
    n = count;
    if (n > MAX_COLORS_DEF) n = MAX_COLORS_DEF;
    c = NO_COLOR;
    if (n != 0 && int'(idx) < n) begin
      j = (int'(idx) * (n / 2 + 1)) % n;
      hue = (HUE_FULL * j) / n;
      ofs = hue % SECTOR_DEG;
      rise = (17 * ofs) / 4;
      fall = (17 * (SECTOR_DEG - ofs)) / 4;
      case (sector_t'(hue / SECTOR_DEG))
        SEC_GREEN_RISE: begin c.red = CH_FULL;    c.green = rise[7:0]; c.blue = '0;        end
        SEC_RED_FALL:   begin c.red = fall[7:0];  c.green = CH_FULL;   c.blue = '0;        end
        SEC_BLUE_RISE:  begin c.red = '0;         c.green = CH_FULL;   c.blue = rise[7:0]; end
        SEC_GREEN_FALL: begin c.red = '0;         c.green = fall[7:0]; c.blue = CH_FULL;   end
        SEC_RED_RISE:   begin c.red = rise[7:0];  c.green = '0;        c.blue = CH_FULL;   end
        default:        begin c.red = CH_FULL;    c.green = '0;        c.blue = fall[7:0]; end
      endcase
      c.alpha = CH_FULL;
      c.valid_res = 1'b1;
    end
    return c;
  endfunction

  task automatic note_mismatch(input string what, input color_t want, input color_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected r=%0d g=%0d b=%0d a=%0d v=%0d, got r=%0d g=%0d b=%0d a=%0d v=%0d",
               $time, what, want.red, want.green, want.blue, want.alpha, want.valid_res,
               got.red, got.green, got.blue, got.alpha, got.valid_res);
  endtask

  // Offer one domain index, idling at random first, and record its color on acceptance.
  task automatic send_index(input logic [IDX_W-1:0] idx, input logic typed, input color_t want);
    while (!steady && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, idx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_colors.push_back(typed ? want : wheel_color(cur_count, idx));
  endtask

  // Stop sending and wait for every outstanding color.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  // Program the color count while the block is idle, then read it back.
  task automatic set_count(input logic [CNT_W-1:0] value);
    drain_results();
    repeat (SETTLE) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= COUNT_ADDR;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata[CNT_W-1:0] !== value) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t color_count readback: expected %0d, got %0d",
                 $time, value, cfg_prdata[CNT_W-1:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cur_count = value;
    @(posedge clk);
  endtask

  // Result side: random back-pressure and the check of each transaction.
  always @(posedge clk) begin
    color_t got;
    color_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tdata[15:8], out_tdata[23:16], out_tdata[31:24], out_tuser[0]};
      if (pending_colors.size() == 0) begin
        note_mismatch("unexpected result", NO_COLOR, got);
      end else begin
        want = pending_colors.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.valid_res !== want.valid_res)
          note_mismatch("color mismatch", want, got);
      end
    end
    out_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t         dir_rows [DIR_N];
    logic [CNT_W-1:0] phase_counts [PHASES];
    logic [IDX_W-1:0] idx;
    int unsigned      n_eff;

    // Reset count, every sector, unknown domains, zero and saturated counts.
    dir_rows = '{
      '{13'd8,    12'd0,    1'b1, PURE_RED},
      '{13'd8,    12'd1,    1'b0, NO_COLOR},
      '{13'd8,    12'd2,    1'b0, NO_COLOR},
      '{13'd8,    12'd3,    1'b0, NO_COLOR},
      '{13'd8,    12'd4,    1'b0, NO_COLOR},
      '{13'd8,    12'd5,    1'b0, NO_COLOR},
      '{13'd8,    12'd6,    1'b0, NO_COLOR},
      '{13'd8,    12'd7,    1'b0, NO_COLOR},
      '{13'd8,    12'd8,    1'b1, NO_COLOR},
      '{13'd8,    12'd4095, 1'b1, NO_COLOR},
      '{13'd0,    12'd0,    1'b1, NO_COLOR},
      '{13'd0,    12'd4095, 1'b1, NO_COLOR},
      '{13'd1,    12'd0,    1'b1, PURE_RED},
      '{13'd1,    12'd1,    1'b1, NO_COLOR},
      '{13'd2,    12'd1,    1'b0, NO_COLOR},
      '{13'd6,    12'd5,    1'b0, NO_COLOR},
      '{13'd4096, 12'd0,    1'b1, PURE_RED},
      '{13'd4096, 12'd4095, 1'b0, NO_COLOR},
      '{13'd4096, 12'd2730, 1'b0, NO_COLOR},
      '{13'd4097, 12'd4095, 1'b0, NO_COLOR},
      '{13'd8191, 12'd0,    1'b1, PURE_RED},
      '{13'd8191, 12'd4095, 1'b0, NO_COLOR},
      '{13'd360,  12'd359,  1'b0, NO_COLOR},
      '{13'd360,  12'd180,  1'b0, NO_COLOR},
      '{13'd4095, 12'd4095, 1'b1, NO_COLOR}
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows; the count is reprogrammed whenever a row asks for a new one.
    for (int r = 0; r < DIR_N; r++) begin
      if (dir_rows[r].count != cur_count) set_count(dir_rows[r].count);
      send_index(dir_rows[r].idx, dir_rows[r].typed, dir_rows[r].want);
    end

    // Random phases: full wheel, mid, saturated, tiny, empty, small, full again.
    phase_counts[0] = 13'd4096;
    phase_counts[1] = 13'($urandom_range(1, 4095));
    phase_counts[2] = 13'($urandom_range(4097, 8191));
    phase_counts[3] = 13'd3;
    phase_counts[4] = 13'd0;
    phase_counts[5] = 13'($urandom_range(2, 64));
    phase_counts[6] = 13'd4096;

    for (int p = 0; p < PHASES; p++) begin
      set_count(phase_counts[p]);
      steady = (p == 0);
      n_eff = (phase_counts[p] > MAX_COLORS_DEF) ? MAX_COLORS_DEF : phase_counts[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Hold off once mid-phase until the pipeline has emptied.
        if (p == 1 && k == PHASE_ITEMS / 2) drain_results();
        if (n_eff != 0 && $urandom_range(0, 99) < 80)
          idx = IDX_W'($urandom_range(0, n_eff - 1));
        else
          idx = IDX_W'($urandom_range(0, 4095));
        send_index(idx, 1'b0, NO_COLOR);
      end
    end
    steady = 1'b0;

    // Let the last colors come out, then allow the pipeline latency to pass.
    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (pending_colors.size() != 0) mismatches += pending_colors.size();

    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- hue_wheel_palette_color.f -----
rtl/hwpc_pkg.sv
rtl/hwpc_front.sv
rtl/hwpc_queue.sv
rtl/hwpc_back.sv
rtl/hue_wheel_palette_color.sv
bench/tb.sv
